// ===== design/mtsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsq_pkg
// Types, codes and default sizes shared by the sequenced topic queue modules.
// ----------------------------------------------------------------------------
package mtsq_pkg;

   localparam int DEFAULT_TOPICS     = 3;
   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   localparam int WORD_W   = 32;
   localparam int LIMIT_W  = 5;
   localparam int OCC_W    = 5;
   localparam int STATUS_W = 3;
   localparam int CMD_W    = 2;
   localparam int TOPIC_W  = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;
   localparam logic [WORD_W-1:0]  COUNT_MAX   = 32'hFFFF_FFFF;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DEQ_EMPTY = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd5;
   localparam logic [STATUS_W-1:0] ST_MOVED     = 3'd6;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd7;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [TOPIC_W-1:0] topic;
      logic [WORD_W-1:0]  payload;
      logic [WORD_W-1:0]  cursor;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                not_yet_valid;
      logic [WORD_W-1:0]   entry_number;
      logic [WORD_W-1:0]   data_out;
      logic [WORD_W-1:0]   next_cursor;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

   // Result of one step without the data word, which arrives from the store.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                not_yet_valid;
      logic [WORD_W-1:0]   entry_number;
      logic [WORD_W-1:0]   next_cursor;
      logic [OCC_W-1:0]    occupancy;
      logic                data_sel;
   } result_type;

endpackage

// ===== design/mtsq_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsq_store
// Entry store for all topics: one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtsq_store #(
   parameter int ENTRIES = 48,
   parameter int DATA_W  = 32,
   parameter int ADDR_W  = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data_ff
);

   logic [DATA_W-1:0] mem [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== design/mtsq_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtsq_engine
// Per-topic ring pointers and counters, command decode and store addressing.
// ----------------------------------------------------------------------------
module mtsq_engine #(
   parameter int TOPICS = mtsq_pkg::DEFAULT_TOPICS,
   parameter int DEPTH  = mtsq_pkg::DEFAULT_DEPTH,
   parameter int DATA_W = mtsq_pkg::DEFAULT_DATA_WIDTH,
   parameter int ADDR_W = $clog2(TOPICS * DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  mtsq_pkg::req_type                   item,
   input  logic [mtsq_pkg::LIMIT_W-1:0]        limit,
   output mtsq_pkg::result_type                result,
   output logic                                wr_en,
   output logic [ADDR_W-1:0]                   wr_addr,
   output logic [DATA_W-1:0]                   wr_data,
   output logic                                rd_en,
   output logic [ADDR_W-1:0]                   rd_addr
);

   localparam int PtrW   = $clog2(DEPTH);
   localparam int TopicW = (TOPICS > 1) ? $clog2(TOPICS) : 1;

   logic [PtrW-1:0]              head_ff  [TOPICS];
   logic [mtsq_pkg::OCC_W-1:0]   fill_ff  [TOPICS];
   logic [mtsq_pkg::WORD_W-1:0]  total_ff [TOPICS];

   logic [PtrW-1:0]              head_in;
   logic [mtsq_pkg::OCC_W-1:0]   fill_in;
   logic [mtsq_pkg::WORD_W-1:0]  total_in;

   logic [TopicW-1:0]            tsel;
   logic                         topic_ok;
   logic [PtrW-1:0]              head;
   logic [mtsq_pkg::OCC_W-1:0]   fill;
   logic [mtsq_pkg::WORD_W-1:0]  total;
   logic [mtsq_pkg::WORD_W-1:0]  oldest;
   logic [mtsq_pkg::LIMIT_W-1:0] lim_used;
   logic [PtrW-1:0]              wr_off;
   logic [PtrW-1:0]              rd_off;
   logic [PtrW:0]                wr_sum;
   logic [PtrW:0]                rd_sum;
   logic [PtrW-1:0]              wr_slot;
   logic [PtrW-1:0]              rd_slot;
   logic [ADDR_W-1:0]            base;
   logic                         do_enq;
   logic                         do_deq;
   logic                         do_rd;
   logic                         moved;

   assign topic_ok = (32'(item.topic) < 32'(TOPICS));
   assign tsel     = TopicW'(item.topic);
   assign head     = topic_ok ? head_ff[tsel]  : '0;
   assign fill     = topic_ok ? fill_ff[tsel]  : '0;
   assign total    = topic_ok ? total_ff[tsel] : '0;
   assign oldest   = total - 32'(fill);

   always_comb begin
      if (limit == '0) begin
         lim_used = mtsq_pkg::LIMIT_W'(1);
      end else if (32'(limit) > 32'(DEPTH)) begin
         lim_used = mtsq_pkg::LIMIT_W'(DEPTH);
      end else begin
         lim_used = limit;
      end
   end

   // Ring slots: the offset never reaches DEPTH, so one subtract wraps the sum.
   assign wr_off  = PtrW'(fill);
   assign rd_off  = moved ? '0 : PtrW'(item.cursor - oldest);
   assign wr_sum  = {1'b0, head} + {1'b0, wr_off};
   assign rd_sum  = {1'b0, head} + {1'b0, rd_off};
   assign wr_slot = (32'(wr_sum) >= 32'(DEPTH)) ? PtrW'(32'(wr_sum) - 32'(DEPTH))
                                                 : PtrW'(wr_sum);
   assign rd_slot = (32'(rd_sum) >= 32'(DEPTH)) ? PtrW'(32'(rd_sum) - 32'(DEPTH))
                                                 : PtrW'(rd_sum);
   assign base    = ADDR_W'(32'(tsel) * 32'(DEPTH));

   always_comb begin
      result.status        = mtsq_pkg::ST_EMPTY;
      result.not_yet_valid = 1'b0;
      result.entry_number  = '0;
      result.next_cursor   = item.cursor;
      result.occupancy     = fill;
      result.data_sel      = 1'b0;
      do_enq = 1'b0;
      do_deq = 1'b0;
      do_rd  = 1'b0;
      moved  = 1'b0;
      case (item.command)
         mtsq_pkg::CMD_ENQUEUE: begin
            if (!topic_ok || fill >= lim_used) begin
               result.status = mtsq_pkg::ST_FULL;
            end else if (total == mtsq_pkg::COUNT_MAX) begin
               result.status = mtsq_pkg::ST_EXHAUSTED;
            end else begin
               result.status       = mtsq_pkg::ST_ENQUEUED;
               result.entry_number = total;
               result.occupancy    = fill + 1'b1;
               do_enq = 1'b1;
            end
         end
         mtsq_pkg::CMD_DEQUEUE: begin
            if (!topic_ok || fill == '0) begin
               result.status = mtsq_pkg::ST_DEQ_EMPTY;
            end else begin
               result.status    = mtsq_pkg::ST_DEQUEUED;
               result.occupancy = fill - 1'b1;
               do_deq = 1'b1;
            end
         end
         mtsq_pkg::CMD_READ: begin
            if (topic_ok && fill != '0) begin
               if (item.cursor < oldest) begin
                  result.status       = mtsq_pkg::ST_MOVED;
                  result.entry_number = oldest;
                  result.next_cursor  = oldest;
                  result.data_sel     = 1'b1;
                  moved = 1'b1;
                  do_rd = 1'b1;
               end else if (item.cursor < total) begin
                  result.status       = mtsq_pkg::ST_FOUND;
                  result.entry_number = item.cursor;
                  result.next_cursor  = item.cursor + 1'b1;
                  result.data_sel     = 1'b1;
                  do_rd = 1'b1;
               end else begin
                  result.not_yet_valid = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign wr_en   = fire && do_enq;
   assign wr_addr = base + ADDR_W'(wr_slot);
   assign wr_data = DATA_W'(item.payload);
   assign rd_en   = fire && do_rd;
   assign rd_addr = base + ADDR_W'(rd_slot);

   assign head_in  = (32'(head) == DEPTH - 1) ? '0 : head + 1'b1;
   assign fill_in  = result.occupancy;
   assign total_in = total + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TOPICS; t++) begin
            head_ff[t]  <= '0;
            fill_ff[t]  <= '0;
            total_ff[t] <= '0;
         end
      end else if (fire) begin
         if (do_enq) begin
            fill_ff[tsel]  <= fill_in;
            total_ff[tsel] <= total_in;
         end
         if (do_deq) begin
            fill_ff[tsel] <= fill_in;
            head_ff[tsel] <= head_in;
         end
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      topic_ok |-> 32'(fill) <= DEPTH)
      else $error("topic fill exceeds its ring depth");

   a_enq_read_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("store written and read by the same step");

   a_total_steps: assert property (@(posedge clock) disable iff (reset)
      fire && do_enq |=> total_ff[$past(tsel)] == $past(total) + 1'b1)
      else $error("entry counter did not advance on enqueue");

endmodule

// ===== design/multi_topic_sequenced_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_topic_sequenced_queue
// Several bounded topic FIFOs whose entries carry consecutive entry numbers.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_data carry one command word: enqueue, dequeue the
//   oldest entry, or read by a reader's cursor. rsp_valid/rsp_stall/rsp_data
//   return exactly one result word per command, in order.
//   csr_valid/csr_ready/csr_data write the queue limit; csr_ready is always
//   high. Write it only while no command is in flight.
//   Path: an accepted word is held in the input register, and its result is
//   loaded into the result register, which drives rsp_data.
//   Throughput: one word per cycle unless the result stalls. The input
//   register feeds a single pass of counter and compare logic that updates
//   the topic registers and the entry store and loads the result register
//   at the same edge; the registered store read is captured at that edge too.
//   Stall: while the result waits, one more word is held in the input
//   register; req_stall rises only when both registers are full.
//   Reset clears every topic (empty, entry numbers from zero) and sets the
//   limit to 16. Store contents are not cleared; only held entries are read.
// ----------------------------------------------------------------------------
module multi_topic_sequenced_queue #(
   parameter int TOPICS     = mtsq_pkg::DEFAULT_TOPICS,
   parameter int DEPTH      = mtsq_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = mtsq_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  mtsq_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output mtsq_pkg::rsp_type             rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mtsq_pkg::LIMIT_W-1:0]  csr_data
);

   localparam int StoreW = (DATA_WIDTH < mtsq_pkg::WORD_W) ? DATA_WIDTH
                                                           : mtsq_pkg::WORD_W;
   localparam int AddrW  = $clog2(TOPICS * DEPTH);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   mtsq_pkg::req_type             in_word_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   mtsq_pkg::result_type          out_res_ff;
   logic [mtsq_pkg::LIMIT_W-1:0]  limit_ff;

   logic                          out_free;
   logic                          advance;
   logic                          accept;
   mtsq_pkg::result_type          result;
   logic                          wr_en;
   logic [AddrW-1:0]              wr_addr;
   logic [StoreW-1:0]             wr_data;
   logic                          rd_en;
   logic [AddrW-1:0]              rd_addr;
   logic [StoreW-1:0]             rd_data;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         limit_ff     <= mtsq_pkg::LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_res_ff <= result;
      end
   end

   mtsq_engine #(
      .TOPICS (TOPICS),
      .DEPTH  (DEPTH),
      .DATA_W (StoreW),
      .ADDR_W (AddrW)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .item    (in_word_ff),
      .limit   (limit_ff),
      .result  (result),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr)
   );

   mtsq_store #(
      .ENTRIES (TOPICS * DEPTH),
      .DATA_W  (StoreW),
      .ADDR_W  (AddrW)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // The store read is captured at the same edge as the result register and
   // is only refreshed by the next read, so it holds while the word stalls.
   always_comb begin
      rsp_data.status        = out_res_ff.status;
      rsp_data.not_yet_valid = out_res_ff.not_yet_valid;
      rsp_data.entry_number  = out_res_ff.entry_number;
      rsp_data.data_out      = out_res_ff.data_sel ? mtsq_pkg::WORD_W'(rd_data) : '0;
      rsp_data.next_cursor   = out_res_ff.next_cursor;
      rsp_data.occupancy     = out_res_ff.occupancy;
   end

   assign rsp_valid = out_valid_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   a_nyv_with_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.not_yet_valid |-> rsp_data.status == mtsq_pkg::ST_EMPTY)
      else $error("not-yet-valid flag without empty status");

   a_data_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && out_res_ff.data_sel |->
         rsp_data.status == mtsq_pkg::ST_FOUND || rsp_data.status == mtsq_pkg::ST_MOVED)
      else $error("data word selected for a result that returns no entry");

endmodule
